[design/gwt_pkg.sv]
// ----------------------------------------------------------------------------
// gwt_pkg: shared types and constants of the G-code word tokenizer
// Character codes, result kinds, parser phases and the result item layout.
// ----------------------------------------------------------------------------
package gwt_pkg;

	// character codes
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_A     = 8'h41;
	localparam logic [7:0] CH_Z     = 8'h5A;

	typedef enum logic [1:0] {
		KIND_WORD     = 2'd0,
		KIND_EOL      = 2'd1,
		KIND_BADNUM   = 2'd2,
		KIND_NOLETTER = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		PH_BETWEEN = 2'd0,
		PH_LETTER  = 2'd1,
		PH_NUMBER  = 2'd2,
		PH_IGNORE  = 2'd3
	} phase_t;

	typedef struct packed {
		kind_t       kind;
		logic [4:0]  letter_index;
		logic [30:0] mantissa;
		logic [3:0]  frac_digits;
		logic        overflowed;
		logic        last;
	} res_t;

	// up to two results pushed per accepted byte
	typedef struct packed {
		logic [1:0] vld;
		res_t       r0;
		res_t       r1;
	} push_t;

	// 10^n - 1, elaboration only
	function automatic logic [63:0] pow10m1(input int n);
		logic [63:0] v;
		v = 64'd1;
		for (int i = 0; i < n; i++) begin
			v = v * 64'd10;
		end
		return v - 64'd1;
	endfunction

endpackage

[design/gcode_word_tokenizer_unit.sv]
// ----------------------------------------------------------------------------
// gcode_word_tokenizer_unit: G-code line tokenizer
// Splits a byte stream of G-code lines into letter/number words.
// ----------------------------------------------------------------------------
// Usage:
//  - Slave channel (s_*): one byte of the line per item; a 0 byte ends the line.
//  - Master channel (m_*): one result item per word, end of line or error.
//    tuser carries the kind, tlast flags the final result of a byte.
//  - A byte gives zero, one or two results (a word closed by the byte that
//    also ends the line or is itself a stray non-letter).
//  - Each result is written into the result queue and presented from its head.
//  - Throughput: one byte per cycle while the queue has room; the master side
//    drains one result per cycle while m_tready is high, so a two-result byte
//    is handed out as two items. The rate is set by the four-entry result
//    queue, which takes a byte whenever two slots are free.
//  - Receiver stall: results wait in the queue while bytes keep flowing until
//    it holds three results, then s_tready drops.
//  - Reset (arst_n low): parser returns to "between words", number state
//    clears, the result queue empties.
// ----------------------------------------------------------------------------
module gcode_word_tokenizer_unit #(
	parameter int MAX_DIGITS = 9
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_code
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [4:0] letter_index, [35:5] mantissa,
	                               // [39:36] frac_digits, [40] overflowed, zero pad
	output logic [1:0]  m_tuser,   // [1:0] kind
	output logic        m_tlast    // last result of the byte
);

	gwt_pkg::push_t push;
	gwt_pkg::res_t  head;
	logic           accept;

	assign accept = s_tvalid && s_tready;

	// parse state and per-byte result generation
	gwt_core #(
		.MAX_DIGITS(MAX_DIGITS)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.char_code(s_tdata),
		.push     (push)
	);

	// result queue decouples the byte side from the result side
	gwt_res_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.room     (s_tready),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_res  (head)
	);

	assign m_tdata = {7'd0, head.overflowed, head.frac_digits, head.mantissa,
		head.letter_index};
	assign m_tuser = head.kind;
	assign m_tlast = head.last;

endmodule

[design/gwt_core.sv]
// ----------------------------------------------------------------------------
// gwt_core: per-byte tokenizer state and result generation
// Holds the parse state; one accepted byte gives zero, one or two results.
// ----------------------------------------------------------------------------
module gwt_core #(
	parameter int MAX_DIGITS = 9
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           accept,
	input  logic [7:0]     char_code,
	output gwt_pkg::push_t push
);

	localparam logic [63:0] LIM64  = gwt_pkg::pow10m1(MAX_DIGITS);
	localparam int          ACC_W  = $clog2(LIM64 + 64'd1);
	localparam int          FRAC_W = $clog2(MAX_DIGITS + 1);
	localparam logic [ACC_W-1:0]   LIM_ACC = LIM64[ACC_W-1:0];
	localparam logic [ACC_W+3:0]   LIM_P   = LIM64[ACC_W+3:0];
	localparam logic [FRAC_W-1:0]  FRAC_MAX = FRAC_W'(MAX_DIGITS);

	gwt_pkg::phase_t   phase_q, phase_d;
	logic [4:0]        letter_q, letter_d;
	logic [ACC_W-1:0]  acc_q, acc_d;
	logic [FRAC_W-1:0] frac_q, frac_d;
	logic              point_q, point_d;
	logic              minus_q, minus_d;
	logic              plus_q, plus_d;
	logic              skip_q, skip_d;
	logic              sat_q, sat_d;

	logic [ACC_W+3:0]  prod;
	logic              fits;
	logic              is_digit, is_letter, is_eol_ch;
	logic [7:0]        letter_off;
	logic [ACC_W+30:0] acc_wide, mant_wide;
	logic [FRAC_W+3:0] frac_wide;
	gwt_pkg::res_t     word_res, bw_res;
	logic              do_bw, bw_emit, word_first, end_num;

	// acc*10 + digit
	assign prod = {acc_q, 3'b000} + {1'b0, acc_q, 1'b0} + {{ACC_W{1'b0}}, char_code[3:0]};
	assign fits = !sat_q && (prod <= LIM_P);

	assign is_digit   = (char_code >= gwt_pkg::CH_0) && (char_code <= gwt_pkg::CH_9);
	assign is_letter  = (char_code >= gwt_pkg::CH_A) && (char_code <= gwt_pkg::CH_Z);
	assign is_eol_ch  = (char_code == gwt_pkg::CH_SEMI) || (char_code == gwt_pkg::CH_CR) ||
		(char_code == gwt_pkg::CH_LF);
	assign letter_off = char_code - gwt_pkg::CH_A;

	assign acc_wide  = {31'd0, acc_q};
	assign mant_wide = minus_q ? (~acc_wide + 1'b1) : acc_wide;
	assign frac_wide = {4'd0, frac_q};

	always_comb begin
		word_res              = '0;
		word_res.kind         = gwt_pkg::KIND_WORD;
		word_res.letter_index = letter_q;
		word_res.mantissa     = mant_wide[30:0];
		word_res.frac_digits  = frac_wide[3:0];
		word_res.overflowed   = sat_q;
	end

	always_comb begin
		phase_d    = phase_q;
		letter_d   = letter_q;
		acc_d      = acc_q;
		frac_d     = frac_q;
		point_d    = point_q;
		minus_d    = minus_q;
		plus_d     = plus_q;
		skip_d     = skip_q;
		sat_d      = sat_q;
		push       = '0;
		do_bw      = 1'b0;
		bw_emit    = 1'b0;
		bw_res     = '0;
		word_first = 1'b0;
		end_num    = 1'b0;

		case (phase_q)
			gwt_pkg::PH_BETWEEN: begin
				if (char_code == gwt_pkg::CH_NUL) begin
					push.vld[0]  = 1'b1;
					push.r0      = '0;
					push.r0.kind = gwt_pkg::KIND_EOL;
				end else begin
					do_bw = 1'b1;
				end
			end
			gwt_pkg::PH_LETTER, gwt_pkg::PH_NUMBER: begin
				if (char_code == gwt_pkg::CH_NUL) begin
					phase_d = gwt_pkg::PH_BETWEEN;
					push.r0 = '0;
					if (phase_q == gwt_pkg::PH_LETTER) begin
						push.vld[0]  = 1'b1;
						push.r0.kind = gwt_pkg::KIND_BADNUM;
					end else begin
						push.vld     = 2'b11;
						push.r0      = word_res;
						push.r1      = '0;
						push.r1.kind = gwt_pkg::KIND_EOL;
					end
				end else begin
					phase_d = gwt_pkg::PH_NUMBER;
					if (char_code == gwt_pkg::CH_PLUS) begin
						if (skip_q && !plus_q) begin
							plus_d = 1'b1;
							skip_d = 1'b0;
						end else begin
							end_num = 1'b1;
						end
					end else if (char_code == gwt_pkg::CH_MINUS && skip_q && !minus_q) begin
						minus_d = 1'b1;
						skip_d  = 1'b0;
					end else if (char_code == gwt_pkg::CH_DOT) begin
						if (point_q) begin
							end_num = 1'b1;
						end else begin
							point_d = 1'b1;
						end
					end else if (is_digit) begin
						skip_d = 1'b0;
						if (!point_q) begin
							if (fits) begin
								acc_d = prod[ACC_W-1:0];
							end else begin
								acc_d = LIM_ACC;
								sat_d = 1'b1;
							end
						end else if (fits && (frac_q < FRAC_MAX)) begin
							acc_d  = prod[ACC_W-1:0];
							frac_d = frac_q + 1'b1;
						end
					end else begin
						end_num = !skip_q;
					end
					if (end_num) begin
						// ending byte: emit word, then reparse byte as word start
						word_first = 1'b1;
						phase_d    = gwt_pkg::PH_BETWEEN;
						acc_d      = acc_q;
						do_bw      = 1'b1;
					end
				end
			end
			default: begin
				if (char_code == gwt_pkg::CH_NUL) begin
					phase_d = gwt_pkg::PH_BETWEEN;
				end
			end
		endcase

		// byte where a word is expected (never NUL here)
		if (do_bw) begin
			if (char_code == gwt_pkg::CH_SPACE) begin
				bw_emit = 1'b0;
			end else if (is_eol_ch) begin
				bw_emit     = 1'b1;
				bw_res.kind = gwt_pkg::KIND_EOL;
				phase_d     = gwt_pkg::PH_IGNORE;
			end else if (is_letter) begin
				letter_d = letter_off[4:0];
				acc_d    = '0;
				frac_d   = '0;
				point_d  = 1'b0;
				minus_d  = 1'b0;
				plus_d   = 1'b0;
				skip_d   = 1'b1;
				sat_d    = 1'b0;
				phase_d  = gwt_pkg::PH_LETTER;
			end else begin
				bw_emit     = 1'b1;
				bw_res.kind = gwt_pkg::KIND_NOLETTER;
				phase_d     = gwt_pkg::PH_IGNORE;
			end
			if (word_first) begin
				push.vld[0] = 1'b1;
				push.r0     = word_res;
				push.vld[1] = bw_emit;
				push.r1     = bw_res;
			end else begin
				push.vld[0] = bw_emit;
				push.r0     = bw_res;
			end
		end

		// mark the final result of this byte
		if (push.vld[1]) begin
			push.r1.last = 1'b1;
		end else if (push.vld[0]) begin
			push.r0.last = 1'b1;
		end

		if (!accept) begin
			push.vld = 2'b00;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= gwt_pkg::PH_BETWEEN;
			letter_q <= '0;
			acc_q    <= '0;
			frac_q   <= '0;
			point_q  <= 1'b0;
			minus_q  <= 1'b0;
			plus_q   <= 1'b0;
			skip_q   <= 1'b1;
			sat_q    <= 1'b0;
		end else if (accept) begin
			phase_q  <= phase_d;
			letter_q <= letter_d;
			acc_q    <= acc_d;
			frac_q   <= frac_d;
			point_q  <= point_d;
			minus_q  <= minus_d;
			plus_q   <= plus_d;
			skip_q   <= skip_d;
			sat_q    <= sat_d;
		end
	end

endmodule

[design/gwt_res_fifo.sv]
// ----------------------------------------------------------------------------
// gwt_res_fifo: four-entry result queue
// Takes up to two results per cycle, hands out one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module gwt_res_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  gwt_pkg::push_t push,
	output logic           room,
	output logic           out_valid,
	input  logic           out_ready,
	output gwt_pkg::res_t  out_res
);

	gwt_pkg::res_t mem_q [4];
	logic [1:0]    wr_ptr_q, rd_ptr_q, wr_ptr_p1;
	logic [2:0]    count_q;
	logic          pop;
	logic [1:0]    n_push;

	assign wr_ptr_p1 = wr_ptr_q + 2'd1;
	assign pop       = out_valid && out_ready;
	assign n_push    = {1'b0, push.vld[0]} + {1'b0, push.vld[1]};
	assign out_valid = (count_q != 3'd0);
	assign out_res   = mem_q[rd_ptr_q];
	// two free slots needed for a worst-case byte
	assign room      = (count_q <= 3'd2);

	always_ff @(posedge clk) begin
		if (push.vld[0]) begin
			mem_q[wr_ptr_q] <= push.r0;
		end
		if (push.vld[1]) begin
			mem_q[wr_ptr_p1] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + n_push;
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 2'd1;
			end
			count_q <= count_q + {1'b0, n_push} - {2'b00, pop};
		end
	end

endmodule
